>>> hdl/randomized_multiset_table_assert.svh
// ----------------------------------------------------------------------------
// randomized_multiset_table_assert.svh
// Assertion macros for the multiset table; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_MULTISET_TABLE_ASSERT_SVH
`define RANDOMIZED_MULTISET_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RMT_ASSERT_IMP(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
    else $error("rmt assertion failed");

// next-cycle implication
`define RMT_ASSERT_NXT(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
    else $error("rmt assertion failed");

`else

`define RMT_ASSERT_IMP(label, clock, reset, lhs, rhs)
`define RMT_ASSERT_NXT(label, clock, reset, lhs, rhs)

`endif

`endif

>>> hdl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Types, codes and sizes shared by the multiset table modules.
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int CAPACITY      = 1024;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int COUNT_FIELD_W = 11;
  localparam int WORD_W        = 32;
  localparam int DIV_STEPS     = WORD_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] value;
    logic [WORD_W-1:0]        random_word;
  } rmt_req_t;

  typedef struct packed {
    logic                      result_flag;
    logic signed [WORD_W-1:0]  sampled_value;
    logic [1:0]                status;
    logic [COUNT_FIELD_W-1:0]  stored_count;
  } rmt_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic ins_wr;
    logic rd_last;
    logic rm_wr;
    logic div_init;
    logic div_step;
    logic smp_rd;
    logic finish;
  } rmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       scan_hit;
    logic       scan_done;
    logic       div_last;
    logic       out_busy;
  } rmt_stat_t;

endpackage

>>> hdl/rmt_datapath.sv
// ----------------------------------------------------------------------------
// rmt_datapath
// Slot memory, element count, match scan, serial modulo and result register.
// ----------------------------------------------------------------------------
module rmt_datapath
  import rmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rmt_req_t  req,
  input  rmt_cmd_t  cmd,
  output rmt_stat_t stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rmt_rsp_t  rsp
);

  logic signed [WORD_W-1:0] mem [CAPACITY];
  logic signed [WORD_W-1:0] rd_data;

  logic [CNT_W-1:0]         count;
  logic [1:0]               op;
  logic signed [WORD_W-1:0] value;
  logic [WORD_W-1:0]        dividend;
  logic                     full;
  logic                     empty;

  logic [CNT_W-1:0]         scan_idx;
  logic                     pend;
  logic [ADDR_W-1:0]        pend_addr;
  logic                     hit;
  logic [ADDR_W-1:0]        hit_pos;
  logic                     hit_now;

  logic [CNT_W-1:0]         rem;
  logic [CNT_W:0]           rem_sh;
  logic [DIV_CNT_W-1:0]     div_cnt;

  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     scan_issue;

  assign scan_issue = cmd.scan_run && (scan_idx < count);
  assign hit_now    = pend && (rd_data == value);
  assign rem_sh     = {rem, dividend[WORD_W-1]};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[ADDR_W-1:0];
    if (scan_issue) begin
      rd_en = 1'b1;
    end else if (cmd.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(count - CNT_W'(1));
    end else if (cmd.smp_rd) begin
      rd_en   = 1'b1;
      rd_addr = rem[ADDR_W-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.ins_wr || cmd.rm_wr;
    wr_addr = cmd.ins_wr ? count[ADDR_W-1:0] : hit_pos;
    wr_data = cmd.ins_wr ? value : rd_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // operand capture, serial modulo and scan position capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req.command;
      value    <= req.value;
      dividend <= req.random_word;
      full     <= (count >= CNT_W'(CAPACITY));
      empty    <= (count == '0);
    end else if (cmd.div_step) begin
      dividend <= {dividend[WORD_W-2:0], 1'b0};
    end
    if (cmd.div_init) begin
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (rem_sh >= {1'b0, count}) begin
        rem <= CNT_W'(rem_sh - {1'b0, count});
      end else begin
        rem <= rem_sh[CNT_W-1:0];
      end
    end
    if (cmd.scan_run && hit_now) begin
      hit_pos <= pend_addr;
    end
    if (scan_issue) begin
      pend_addr <= scan_idx[ADDR_W-1:0];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.scan_run && hit_now) begin
        hit <= 1'b1;
      end
      if (cmd.scan_init) begin
        scan_idx <= '0;
        pend     <= 1'b0;
      end else if (cmd.scan_run) begin
        pend <= scan_issue;
        if (scan_issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
      end
      if (cmd.ins_wr) begin
        count <= count + CNT_W'(1);
      end else if (cmd.rm_wr) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.result_flag   <= ((op == CMD_INSERT) && !full && !hit) ||
                           ((op == CMD_REMOVE) && hit);
      rsp.sampled_value <= ((op == CMD_SAMPLE) && !empty) ? rd_data : '0;
      if ((op == CMD_INSERT) && full) begin
        rsp.status <= ST_FULL;
      end else if ((op == CMD_SAMPLE) && empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.status <= ST_OK;
      end
      rsp.stored_count  <= COUNT_FIELD_W'(count);
    end
  end

  always_comb begin
    stat.op        = op;
    stat.full      = full;
    stat.empty     = empty;
    stat.scan_hit  = hit_now;
    stat.scan_done = !pend && (scan_idx >= count);
    stat.div_last  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    stat.out_busy  = rsp_valid && !rsp_ready;
  end

endmodule

>>> hdl/rmt_ctrl.sv
// ----------------------------------------------------------------------------
// rmt_ctrl
// Sequencer for insert, remove and sample operations.
// ----------------------------------------------------------------------------
module rmt_ctrl
  import rmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  rmt_stat_t stat,
  output rmt_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_INS_WR,
    S_RD_LAST,
    S_RM_WR,
    S_DIV,
    S_SMP_RD,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE) && !stat.out_busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          CMD_INSERT: begin
            if (stat.full) begin
              state_next = S_FINISH;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          CMD_REMOVE: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          CMD_SAMPLE: begin
            if (stat.empty) begin
              state_next = S_FINISH;
            end else begin
              cmd.div_init = 1'b1;
              state_next   = S_DIV;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_hit || stat.scan_done) begin
          if (stat.op == CMD_INSERT) begin
            state_next = S_INS_WR;
          end else if (stat.scan_hit) begin
            state_next = S_RD_LAST;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_RD_LAST: begin
        cmd.rd_last = 1'b1;
        state_next  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.rm_wr  = 1'b1;
        state_next = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_SMP_RD;
        end
      end
      S_SMP_RD: begin
        cmd.smp_rd = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/randomized_multiset_table.sv
// ----------------------------------------------------------------------------
// randomized_multiset_table
// Multiset of signed 32-bit values with insert, remove and random sample.
// ----------------------------------------------------------------------------
// Request channel req_valid/req_ready/req carries command, value and
// random_word; response channel rsp_valid/rsp_ready/rsp returns one item
// per request: result_flag, sampled_value, status and stored_count.
// One request is worked on at a time; the next is taken once the previous
// response has left or is being taken in the same cycle.
// Per request: insert and remove scan the stored slots up to the first match;
//   then an insert writes its value into the next free slot, and a remove hit
//   moves the last slot into the hit slot; a sample runs the divider, then reads.
//   A full insert, an empty sample and command 3 go straight to the response.
// The match scan reads one slot a cycle from the slot memory read port,
// and the modulo of random_word by the count is a 32-step restoring
// divider, one quotient bit a cycle.
// Reset empties the table at once (count to zero, no clearing pass); slot
// contents stay as they were and are never read before being written.
// A stalled response holds in its register and blocks further requests.
// ----------------------------------------------------------------------------
`include "randomized_multiset_table_assert.svh"

module randomized_multiset_table
  import rmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  rmt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rmt_rsp_t rsp
);

  rmt_cmd_t  cmd;
  rmt_stat_t stat;

  rmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // a fresh request never finds a response in the register on the next cycle
  `RMT_ASSERT_NXT(a_no_early_rsp, clk, rst, req_valid && req_ready, !rsp_valid)
  // the response register is free whenever a request is taken
  `RMT_ASSERT_IMP(a_rsp_free, clk, rst, req_ready, !rsp_valid || rsp_ready)
  // a full insert stores nothing
  `RMT_ASSERT_IMP(a_full_no_flag, clk, rst, rsp_valid && (rsp.status == ST_FULL),
                  !rsp.result_flag)
  // an empty sample returns zero
  `RMT_ASSERT_IMP(a_empty_zero, clk, rst, rsp_valid && (rsp.status == ST_EMPTY),
                  (rsp.sampled_value == '0) && (rsp.stored_count == '0))

endmodule

>>> tb/randomized_multiset_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_multiset_table testbench
// Drives insert, remove, sample and unused-command requests with random
// gaps and response stalls, keeps a copy of the slot table to work out each
// response, and checks every response item field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import rmt_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         END_WAIT       = CAPACITY + 16;
  localparam int         REPORT_LIMIT   = 10;
  localparam logic signed [WORD_W-1:0] MIN_VALUE = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MAX_VALUE = 32'sh7fff_ffff;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  rmt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  rmt_rsp_t rsp;

  // copy of the table contents as the block should hold them
  logic signed [WORD_W-1:0] held_values [CAPACITY];
  int unsigned              held_count = 0;
  rmt_rsp_t                 awaited_results [$];
  logic signed [WORD_W-1:0] value_pool [8];

  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  randomized_multiset_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 15);
    else return $urandom_range(20, 80);
  endfunction

  // applies one request to the table copy and returns the response it causes
  function automatic rmt_rsp_t apply_table_op(rmt_req_t item);
    rmt_rsp_t    result;
    int unsigned pos;
    logic [31:0] slot;
    result = '0;
    pos = held_count;
    case (item.command)
      CMD_INSERT: begin
        if (held_count >= CAPACITY) begin
          result.status = ST_FULL;
        end else begin
          for (int unsigned i = 0; i < held_count; i++) begin
            if (held_values[i] == item.value && pos == held_count) pos = i;
          end
          result.result_flag = (pos == held_count);
          held_values[held_count] = item.value;
          held_count++;
        end
      end
      CMD_REMOVE: begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_values[i] == item.value && pos == held_count) pos = i;
        end
        if (pos < held_count) begin
          held_values[pos] = held_values[held_count - 1];
          held_count--;
          result.result_flag = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (held_count == 0) begin
          result.status = ST_EMPTY;
        end else begin
          slot = item.random_word % held_count;
          result.sampled_value = held_values[slot];
        end
      end
      default: ;
    endcase
    result.stored_count = held_count[COUNT_FIELD_W-1:0];
    return result;
  endfunction

  // one request item: optional gap, then hold valid until it is taken
  task automatic send_item(input logic [1:0] cmd, input logic signed [WORD_W-1:0] val,
                           input logic [WORD_W-1:0] rword);
    rmt_req_t    item;
    int unsigned gap;
    item.command     = cmd;
    item.value       = val;
    item.random_word = rword;
    gap = ($urandom_range(0, 99) < gap_pct) ? gap_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    awaited_results = {awaited_results, apply_table_op(item)};
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(CMD_REMOVE, 0, $urandom);
    send_item(CMD_SAMPLE, $urandom, 32'h0000_0000);
    send_item(CMD_SAMPLE, $urandom, 32'hffff_ffff);
    send_item(CMD_UNUSED, $urandom, $urandom);
  endtask

  task automatic test_basic_ops();
    send_item(CMD_INSERT, MIN_VALUE, $urandom);
    send_item(CMD_INSERT, MAX_VALUE, $urandom);
    send_item(CMD_INSERT, 0, $urandom);
    send_item(CMD_INSERT, MIN_VALUE, $urandom);   // second copy
    send_item(CMD_INSERT, -1, $urandom);
    send_item(CMD_SAMPLE, $urandom, 32'h0000_0000);
    send_item(CMD_SAMPLE, $urandom, 32'hffff_ffff);
    send_item(CMD_SAMPLE, $urandom, 32'h8000_0003);
    send_item(CMD_SAMPLE, $urandom, 32'd4);
    // lowest copy goes first, last slot moves into it
    send_item(CMD_REMOVE, MIN_VALUE, $urandom);
    send_item(CMD_REMOVE, MIN_VALUE, $urandom);   // now in the last slot
    send_item(CMD_REMOVE, 12345, $urandom);
    send_item(CMD_REMOVE, -1, $urandom);
    send_item(CMD_SAMPLE, $urandom, 32'd1);
    send_item(CMD_UNUSED, MIN_VALUE, 32'hffff_ffff);
    send_item(CMD_REMOVE, MAX_VALUE, $urandom);
    send_item(CMD_REMOVE, 0, $urandom);
    send_item(CMD_REMOVE, 0, $urandom);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value(int unsigned stored_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (held_count != 0 && r < stored_pct) return held_values[$urandom_range(0, held_count - 1)];
    else if (r < 85) return value_pool[$urandom_range(0, 7)];
    else return $urandom;
  endfunction

  function automatic logic [WORD_W-1:0] pick_random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    else if (r < 20) return 32'hffff_ffff;
    else if (r < 35) return $urandom_range(0, 2 * held_count + 1);
    else return $urandom;
  endfunction

  task automatic test_random_mix();
    int unsigned pick;
    int unsigned insert_pct;
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = 1;
    value_pool[3] = MIN_VALUE;
    value_pool[4] = MAX_VALUE;
    for (int i = 5; i < 8; i++) value_pool[i] = $urandom;
    // four phases: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct   = phase[0] ? 30 : 0;
      stall_pct = phase[1] ? 40 : 0;
      for (int n = 0; n < 138; n++) begin
        // keep the count small so that scans stay short
        insert_pct = (held_count < 8) ? 60 : ((held_count > 40) ? 25 : 42);
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
          send_item(CMD_INSERT, pick_value(30), $urandom);
        else if (pick < insert_pct + 30)
          send_item(CMD_REMOVE, pick_value(60), $urandom);
        else if (pick < 95)
          send_item(CMD_SAMPLE, $urandom, pick_random_word());
        else
          send_item(CMD_UNUSED, $urandom, $urandom);
        if (phase == 1 && n == 69) wait_for_drain();
      end
    end
  endtask

  task automatic test_fill_to_capacity();
    logic signed [WORD_W-1:0] anchor;
    logic signed [WORD_W-1:0] fresh;
    gap_pct   = 10;
    stall_pct = 10;
    // repeats of slot 0's value match at once, so filling stays quick
    if (held_count == 0) send_item(CMD_INSERT, $urandom, $urandom);
    anchor = held_values[0];
    fresh  = ~anchor;
    while (held_count < CAPACITY - 1) send_item(CMD_INSERT, anchor, $urandom);
    send_item(CMD_INSERT, fresh, $urandom);
    send_item(CMD_INSERT, MIN_VALUE, $urandom);
    send_item(CMD_INSERT, MAX_VALUE, 32'hffff_ffff);
    send_item(CMD_SAMPLE, $urandom, 32'hffff_ffff);
    send_item(CMD_SAMPLE, $urandom, 32'h0000_0000);
    send_item(CMD_SAMPLE, $urandom, $urandom);
    send_item(CMD_REMOVE, fresh + 1, $urandom);
    send_item(CMD_REMOVE, anchor, $urandom);
    send_item(CMD_INSERT, anchor, $urandom);
    send_item(CMD_REMOVE, fresh, $urandom);
    send_item(CMD_UNUSED, $urandom, $urandom);
    send_item(CMD_INSERT, fresh, $urandom);
    send_item(CMD_INSERT, fresh, $urandom);
    send_item(CMD_SAMPLE, $urandom, CAPACITY - 1);
  endtask

  // response side stalls
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = gap_length();
      end
    end
  end

  always @(posedge clk) begin : check_results
    rmt_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected response item: flag %0d value %0d status %0d count %0d",
                   rsp.result_flag, rsp.sampled_value, rsp.status, rsp.stored_count);
      end else begin
        want = awaited_results.pop_front();
        if (rsp.result_flag !== want.result_flag || rsp.sampled_value !== want.sampled_value ||
            rsp.status !== want.status || rsp.stored_count !== want.stored_count) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.result_flag, want.sampled_value, want.status, want.stored_count,
                     rsp.result_flag, rsp.sampled_value, rsp.status, rsp.stored_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("randomized_multiset_table verification failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_basic_ops();
    test_random_mix();
    test_fill_to_capacity();
    wait_for_drain();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0)
      $display("randomized_multiset_table verification clean");
    else
      $display("randomized_multiset_table verification failed");
    $finish;
  end

endmodule

>>> randomized_multiset_table.f
+incdir+hdl
hdl/rmt_pkg.sv
hdl/rmt_datapath.sv
hdl/rmt_ctrl.sv
hdl/randomized_multiset_table.sv
tb/randomized_multiset_table_tb.sv
